### rtl/ccpf_pkg.sv
// ----------------------------------------------------------------------------
// ccpf_pkg
// Shared types and constants of the central crossing pair finder.
// ----------------------------------------------------------------------------
`default_nettype none

package ccpf_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int FRACTION_BITS   = 8;
  localparam int MAX_SAMPLES_DEF = 4096;
  localparam int NUM_W           = SAMPLE_BITS + 1;
  localparam int OUT_W           = 20;
  localparam int PL_W            = 13;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_W           = 16;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_EDGE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH     = 2'd2;

  localparam logic [PL_W-1:0] PL_RESET = 13'd4096;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } ccpf_in_t;

  typedef struct packed {
    logic             found;
    logic [OUT_W-1:0] pair_start;
    logic [OUT_W-1:0] pair_width;
  } ccpf_out_t;

  typedef enum logic [4:0] {
    PH_OPEN_FIRST  = 5'b00001,
    PH_CLOSE_FIRST = 5'b00010,
    PH_OPEN_NEXT   = 5'b00100,
    PH_CLOSE_NEXT  = 5'b01000,
    PH_DONE        = 5'b10000
  } phase_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic measure;
    logic update;
    logic finish;
  } ccpf_cmd_t;

  typedef struct packed {
    logic crossing;
    logic div_done;
    logic out_blocked;
  } ccpf_sts_t;

endpackage

`default_nettype wire

### rtl/ccpf_div.sv
// ----------------------------------------------------------------------------
// ccpf_div
// Restoring divider, one quotient bit per cycle, for the crossing fraction.
// Requires num < den.
// ----------------------------------------------------------------------------
`default_nettype none

module ccpf_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [ccpf_pkg::NUM_W-1:0]  num,
  input  wire logic [ccpf_pkg::NUM_W-1:0]  den,
  output logic                             done,
  output logic [ccpf_pkg::FRACTION_BITS-1:0] quot
);

  localparam int NW = ccpf_pkg::NUM_W;
  localparam int FB = ccpf_pkg::FRACTION_BITS;
  localparam int CW = $clog2(FB + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] rem;
  logic [NW-1:0] dsr;
  logic [NW:0]   rem_sh;
  logic          take;

  assign rem_sh = {rem, 1'b0};
  assign take   = rem_sh >= {1'b0, dsr};
  assign done   = busy && (cnt == CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(FB);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsr <= den;
    end else if (busy) begin
      rem  <= take ? NW'(rem_sh - {1'b0, dsr}) : NW'(rem_sh);
      quot <= {quot[FB-2:0], take};
    end
  end

endmodule

`default_nettype wire

### rtl/ccpf_dp.sv
// ----------------------------------------------------------------------------
// ccpf_dp
// Datapath: configuration registers, edge test, positions, centre distances,
// best pair tracking and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ccpf_dp #(
  parameter int MAX_SAMPLES = ccpf_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [ccpf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ccpf_pkg::CFG_W-1:0]        cfg_data,
  input  wire ccpf_pkg::ccpf_in_t                item,
  input  wire ccpf_pkg::ccpf_cmd_t               cmd,
  output ccpf_pkg::ccpf_sts_t                    sts,
  output logic                                   result_valid,
  input  wire logic                              result_ready,
  output ccpf_pkg::ccpf_out_t                    result
);

  localparam int SB = ccpf_pkg::SAMPLE_BITS;
  localparam int FB = ccpf_pkg::FRACTION_BITS;
  localparam int NW = ccpf_pkg::NUM_W;
  localparam int PL = ccpf_pkg::PL_W;
  localparam int OW = ccpf_pkg::OUT_W;
  localparam int IW = $clog2(MAX_SAMPLES + 1);
  localparam int HW = $clog2(MAX_SAMPLES);
  localparam int PW = HW + FB;
  localparam int SW = (PW + 1 > PL + FB) ? PW + 1 : PL + FB;

  function automatic logic [NW-1:0] absdiff(logic signed [SB-1:0] a,
                                            logic signed [SB-1:0] b);
    logic signed [NW-1:0] d;
    d = $signed({a[SB-1], a}) - $signed({b[SB-1], b});
    return d[NW-1] ? NW'(-d) : NW'(d);
  endfunction

  logic signed [SB-1:0] threshold;
  logic                 first_edge_falling;
  logic [PL-1:0]        profile_length;

  logic signed [SB-1:0] cur;
  logic                 last_r;
  logic signed [SB-1:0] previous_sample;
  logic [IW-1:0]        sample_index;
  ccpf_pkg::phase_t     search_phase;
  logic [PW-1:0]        best_start;
  logic [PW-1:0]        best_end;
  logic [PW-1:0]        candidate_start;
  logic                 pair_found;
  logic [PW-1:0]        pos_r;
  logic [SW-1:0]        dn;
  logic [SW-1:0]        db;

  logic                 search_ok;
  logic                 opening;
  logic                 rising;
  logic                 rise_edge;
  logic                 fall_edge;
  logic [NW-1:0]        num;
  logic [NW-1:0]        den;
  logic                 div_done;
  logic [FB-1:0]        quot;
  logic [PW-1:0]        pos;
  logic [SW-1:0]        ctr;
  logic [SW-1:0]        sum_n;
  logic [SW-1:0]        sum_b;

  assign search_ok = (sample_index != '0)
                  && (32'(sample_index) < 32'(profile_length))
                  && (32'(sample_index) < MAX_SAMPLES)
                  && (search_phase != ccpf_pkg::PH_DONE);
  assign opening   = (search_phase == ccpf_pkg::PH_OPEN_FIRST)
                  || (search_phase == ccpf_pkg::PH_OPEN_NEXT);
  assign rising    = (first_edge_falling == 1'b0) == opening;
  assign rise_edge = (previous_sample <= threshold) && (cur > threshold);
  assign fall_edge = (previous_sample >= threshold) && (cur < threshold);

  assign num = absdiff(threshold, previous_sample);
  assign den = absdiff(cur, previous_sample);

  ccpf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quot  (quot)
  );

  assign pos   = {HW'(sample_index - IW'(1)), quot};
  assign ctr   = SW'({profile_length, {FB{1'b0}}});
  assign sum_n = SW'(candidate_start) + SW'(pos);
  assign sum_b = SW'(best_start) + SW'(best_end);

  assign sts.crossing    = search_ok && (rising ? rise_edge : fall_edge);
  assign sts.div_done    = div_done;
  assign sts.out_blocked = last_r && result_valid && !result_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur    <= item.sample;
      last_r <= item.last;
    end
    if (cmd.measure) begin
      pos_r <= pos;
      dn    <= (sum_n >= ctr) ? sum_n - ctr : ctr - sum_n;
      db    <= (sum_b >= ctr) ? sum_b - ctr : ctr - sum_b;
    end
    if (cmd.finish && last_r) begin
      result.found      <= pair_found;
      result.pair_start <= OW'(best_start);
      result.pair_width <= OW'(best_end - best_start);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold          <= '0;
      first_edge_falling <= 1'b0;
      profile_length     <= ccpf_pkg::PL_RESET;
      previous_sample    <= '0;
      sample_index       <= '0;
      search_phase       <= ccpf_pkg::PH_OPEN_FIRST;
      best_start         <= '0;
      best_end           <= '0;
      candidate_start    <= '0;
      pair_found         <= 1'b0;
      result_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          ccpf_pkg::REG_THRESHOLD:  threshold          <= cfg_data[SB-1:0];
          ccpf_pkg::REG_FIRST_EDGE: first_edge_falling <= cfg_data[0];
          ccpf_pkg::REG_LENGTH:     profile_length     <= cfg_data[PL-1:0];
          default: ;
        endcase
      end

      if (cmd.update) begin
        case (search_phase)
          ccpf_pkg::PH_OPEN_FIRST: begin
            candidate_start <= pos_r;
            search_phase    <= ccpf_pkg::PH_CLOSE_FIRST;
          end
          ccpf_pkg::PH_CLOSE_FIRST: begin
            best_start   <= candidate_start;
            best_end     <= pos_r;
            pair_found   <= 1'b1;
            search_phase <= ccpf_pkg::PH_OPEN_NEXT;
          end
          ccpf_pkg::PH_OPEN_NEXT: begin
            candidate_start <= pos_r;
            search_phase    <= ccpf_pkg::PH_CLOSE_NEXT;
          end
          ccpf_pkg::PH_CLOSE_NEXT: begin
            if (dn < db) begin
              best_start   <= candidate_start;
              best_end     <= pos_r;
              search_phase <= ccpf_pkg::PH_OPEN_NEXT;
            end else begin
              search_phase <= ccpf_pkg::PH_DONE;
            end
          end
          default: ;
        endcase
      end

      if (cmd.finish && last_r) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end

      if (cmd.finish) begin
        if (last_r) begin
          previous_sample <= '0;
          sample_index    <= '0;
          search_phase    <= ccpf_pkg::PH_OPEN_FIRST;
          best_start      <= '0;
          best_end        <= '0;
          candidate_start <= '0;
          pair_found      <= 1'b0;
        end else begin
          previous_sample <= cur;
          if (32'(sample_index) < MAX_SAMPLES) begin
            sample_index <= sample_index + IW'(1);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/ccpf_ctrl.sv
// ----------------------------------------------------------------------------
// ccpf_ctrl
// Controller: sequences accept, edge test and finish for each item, and
// division, distance and update for an item that completes a crossing.
// ----------------------------------------------------------------------------
`default_nettype none

module ccpf_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_ready,
  input  wire ccpf_pkg::ccpf_sts_t  sts,
  output ccpf_pkg::ccpf_cmd_t       cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_EVAL   = 6'b000010,
    ST_DIV    = 6'b000100,
    ST_DIST   = 6'b001000,
    ST_UPDATE = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign item_ready = (state == ST_IDLE);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts.crossing) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_next = ST_DIST;
        end
      end
      ST_DIST: begin
        cmd.measure = 1'b1;
        state_next  = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts.out_blocked) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### rtl/central_crossing_pair_finder.sv
// ----------------------------------------------------------------------------
// central_crossing_pair_finder
// Finds threshold crossing pairs in a sample profile and reports the pair
// whose midpoint lies nearest the profile centre.
// ----------------------------------------------------------------------------
// Flow: one item at a time; the next item is accepted only once the previous
//   one has finished. The crossing fraction comes from the bit-serial divider.
// Result: registered when the last item finishes; a held result stalls only
//   the next last item.
// Reset: synchronous; clears the profile state and restores the registers
//   to threshold 0, rising first edge, profile length 4096.
`default_nettype none

module central_crossing_pair_finder #(
  parameter int MAX_SAMPLES = ccpf_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [ccpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ccpf_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                            item_valid,
  output logic                                 item_ready,
  input  wire ccpf_pkg::ccpf_in_t              item,
  output logic                                 result_valid,
  input  wire logic                            result_ready,
  output ccpf_pkg::ccpf_out_t                  result
);

  ccpf_pkg::ccpf_cmd_t cmd;
  ccpf_pkg::ccpf_sts_t sts;

  ccpf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ccpf_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (item),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

### rtl/ccpf_checker.sv
// ----------------------------------------------------------------------------
// ccpf_checker
// Port-level checks of the central crossing pair finder, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module ccpf_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                item_valid,
  input wire logic                item_ready,
  input wire logic                result_valid,
  input wire logic                result_ready,
  input wire ccpf_pkg::ccpf_out_t result
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed or dropped while stalled");

  a_none_is_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.found |-> result.pair_start == '0 && result.pair_width == '0)
    else $error("empty result carries a pair");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item taken while previous item in flight");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind central_crossing_pair_finder ccpf_checker u_ccpf_checker (.*);

`default_nettype wire
